FILE: design/rsmw_pkg.sv
`default_nettype none
package rsmw_pkg;

  localparam int MAX_COLS = 64;
  localparam int MAX_ROWS = 64;

  localparam int COL_W     = $clog2(MAX_COLS);
  localparam int ROW_W     = $clog2(MAX_ROWS);
  localparam int ADDR_W    = COL_W + ROW_W;
  localparam int MEM_DEPTH = 1 << ADDR_W;

  localparam int VAL_W   = 32;
  localparam int DIM_W   = 7;
  localparam int COORD_W = 16;
  localparam int POS_W   = COORD_W + 2;
  localparam int CFG_IDX_W = 2;

  localparam logic [VAL_W-1:0] NO_VALUE_RESET = 32'hD8F1_0000;
  localparam logic [DIM_W-1:0] DIM_RESET      = 7'd64;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_WIDTH  = 2'd0,
    REG_GRID_HEIGHT = 2'd1,
    REG_NO_VALUE    = 2'd2,
    REG_UNUSED      = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ACT_WRITE  = 2'd0,
    ACT_READ   = 2'd1,
    ACT_WINDOW = 2'd2,
    ACT_CLEAR  = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_RD,
    ST_LAST,
    ST_CLR,
    ST_DONE
  } state_t;

endpackage
`default_nettype wire

FILE: design/raster_store_moore_window_core.sv
`default_nettype none
// raster store with a 3x3 moore window and running min/max of written values
// input channel (in_valid/in_ready) takes one request: write, read, window or clear;
// each request gives exactly one result on the output channel (out_valid/out_ready)
// all cells live in one synchronous memory with one write and one read port,
// so cell accesses go one at a time through each port
// path from accept to out_valid: write goes straight to the done step; read and window
//   pass the read steps, the last step and done; clear sweeps the clamped cols x rows grid
// the next request is taken once the result has moved into the output register
// window rate is set by the nine reads through the single read port
// the output register holds a finished result while the next request is already
// being worked on; when the receiver stalls the block stops in its done step
// after reset the memory is swept to the reset empty marker, one cell a cycle, over
// all MEM_DEPTH cells (4096 for a 64x64 store), during which in_ready stays low;
// configuration writes are taken at any time, including during that sweep
// configuration is only to be changed while no request is in flight
module raster_store_moore_window_core
  import rsmw_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,

  input  wire logic                     cfg_write_en,
  input  wire logic [CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [VAL_W-1:0]         cfg_data,

  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic [1:0]               in_action,
  input  wire logic signed [COORD_W-1:0] in_col,
  input  wire logic signed [COORD_W-1:0] in_row,
  input  wire logic signed [VAL_W-1:0]  in_cell_value,

  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic signed [VAL_W-1:0]       out_north_west,
  output logic signed [VAL_W-1:0]       out_north,
  output logic signed [VAL_W-1:0]       out_north_east,
  output logic signed [VAL_W-1:0]       out_west,
  output logic signed [VAL_W-1:0]       out_centre,
  output logic signed [VAL_W-1:0]       out_east,
  output logic signed [VAL_W-1:0]       out_south_west,
  output logic signed [VAL_W-1:0]       out_south,
  output logic signed [VAL_W-1:0]       out_south_east,
  output logic                          out_ok,
  output logic signed [VAL_W-1:0]       out_min_seen,
  output logic signed [VAL_W-1:0]       out_max_seen
);

  // configuration
  logic [DIM_W-1:0] grid_w_r;
  logic [DIM_W-1:0] grid_h_r;
  logic [VAL_W-1:0] no_value_r;
  logic [DIM_W-1:0] eff_cols;
  logic [DIM_W-1:0] eff_rows;

  // control
  state_t state_r, state_nxt;
  logic [ADDR_W-1:0] init_cnt_r;
  logic [1:0] kx_r, ky_r;
  logic single_r;
  logic pend_v_r;
  logic [1:0] pend_kx_r, pend_ky_r;
  logic pend_in_r;
  logic [COL_W-1:0] cx_r;
  logic [ROW_W-1:0] cy_r;
  logic out_valid_r;

  // request held while working
  action_t act_r;
  logic signed [COORD_W-1:0] col_r;
  logic signed [COORD_W-1:0] row_r;
  logic ok_r;
  logic [VAL_W-1:0] win_r [9];

  // results
  logic [VAL_W-1:0] out_win_r [9];
  logic out_ok_r;
  logic [VAL_W-1:0] min_r, max_r;
  logic [VAL_W-1:0] out_min_r, out_max_r;

  // memory
  logic [VAL_W-1:0] mem [MEM_DEPTH];
  logic [VAL_W-1:0] rd_data_r;
  logic mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [VAL_W-1:0] mem_wdata;
  logic [ADDR_W-1:0] mem_raddr;

  // datapath helpers
  logic accept;
  action_t in_act;
  logic in_inside;
  logic signed [POS_W-1:0] c_s, r_s, dx_s, dy_s, cc_s, rr_s;
  logic nb_inside;
  logic cx_last, cy_last;
  logic load_out;
  logic [3:0] pend_idx;
  logic wr_stat;
  logic sweep_empty;

  function automatic logic pos_inside(
    input logic signed [POS_W-1:0] c,
    input logic signed [POS_W-1:0] r,
    input logic [DIM_W-1:0] ec,
    input logic [DIM_W-1:0] er
  );
    logic signed [POS_W-1:0] ec_s;
    logic signed [POS_W-1:0] er_s;
    ec_s = $signed({{(POS_W-DIM_W){1'b0}}, ec});
    er_s = $signed({{(POS_W-DIM_W){1'b0}}, er});
    return (c >= 0) && (r >= 0) && (c < ec_s) && (r < er_s);
  endfunction

  assign eff_cols = (32'(grid_w_r) > MAX_COLS) ? DIM_W'(MAX_COLS) : grid_w_r;
  assign eff_rows = (32'(grid_h_r) > MAX_ROWS) ? DIM_W'(MAX_ROWS) : grid_h_r;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign in_act   = action_t'(in_action);
  assign in_inside = pos_inside(POS_W'(in_col), POS_W'(in_row), eff_cols, eff_rows);

  // mirrored neighbour position for the current window step
  always_comb begin
    c_s  = POS_W'(col_r);
    r_s  = POS_W'(row_r);
    dx_s = $signed({{(POS_W-2){1'b0}}, kx_r}) - $signed(POS_W'(1));
    dy_s = $signed({{(POS_W-2){1'b0}}, ky_r}) - $signed(POS_W'(1));
    cc_s = c_s + dx_s;
    rr_s = r_s + dy_s;
    if ((cc_s < 0) || (cc_s >= $signed({{(POS_W-DIM_W){1'b0}}, eff_cols}))) begin
      cc_s = c_s - dx_s;
    end
    if ((rr_s < 0) || (rr_s >= $signed({{(POS_W-DIM_W){1'b0}}, eff_rows}))) begin
      rr_s = r_s - dy_s;
    end
    nb_inside = pos_inside(cc_s, rr_s, eff_cols, eff_rows);
  end

  assign cx_last = (DIM_W'(cx_r) == eff_cols - DIM_W'(1));
  assign cy_last = (DIM_W'(cy_r) == eff_rows - DIM_W'(1));
  assign sweep_empty = (eff_cols == '0) || (eff_rows == '0);
  assign pend_idx = 4'({pend_ky_r, 1'b0}) + 4'(pend_ky_r) + 4'(pend_kx_r);
  assign wr_stat = accept && (in_act == ACT_WRITE) && in_inside
                   && (in_cell_value != no_value_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_INIT: begin
        if (init_cnt_r == ADDR_W'(MEM_DEPTH - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          case (in_act)
            ACT_READ, ACT_WINDOW: state_nxt = ST_RD;
            ACT_CLEAR:            state_nxt = sweep_empty ? ST_DONE : ST_CLR;
            default:              state_nxt = ST_DONE;
          endcase
        end
      end
      ST_RD: begin
        if (single_r || (kx_r == 2'd2 && ky_r == 2'd2)) state_nxt = ST_LAST;
      end
      ST_LAST: begin
        state_nxt = ST_DONE;
      end
      ST_CLR: begin
        if (cx_last && cy_last) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // memory port and output register control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = {in_row[ROW_W-1:0], in_col[COL_W-1:0]};
    mem_wdata = in_cell_value;
    mem_raddr = {rr_s[ROW_W-1:0], cc_s[COL_W-1:0]};
    load_out  = 1'b0;
    case (state_r)
      ST_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = init_cnt_r;
        mem_wdata = NO_VALUE_RESET;
      end
      ST_IDLE: begin
        mem_we = accept && (in_act == ACT_WRITE) && in_inside;
      end
      ST_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = {cy_r, cx_r};
        mem_wdata = no_value_r;
      end
      ST_DONE: begin
        load_out = !out_valid_r || out_ready;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      init_cnt_r  <= '0;
      grid_w_r    <= DIM_RESET;
      grid_h_r    <= DIM_RESET;
      no_value_r  <= NO_VALUE_RESET;
      min_r       <= NO_VALUE_RESET;
      max_r       <= NO_VALUE_RESET;
      out_valid_r <= 1'b0;
      pend_v_r    <= 1'b0;
      kx_r        <= '0;
      ky_r        <= '0;
      single_r    <= 1'b0;
      cx_r        <= '0;
      cy_r        <= '0;
    end else begin
      state_r <= state_nxt;

      if (cfg_write_en) begin
        case (cfg_reg_t'(cfg_index))
          REG_GRID_WIDTH:  grid_w_r   <= cfg_data[DIM_W-1:0];
          REG_GRID_HEIGHT: grid_h_r   <= cfg_data[DIM_W-1:0];
          REG_NO_VALUE:    no_value_r <= cfg_data;
          default:         ;
        endcase
      end

      if (state_r == ST_INIT) begin
        init_cnt_r <= init_cnt_r + ADDR_W'(1);
      end

      if (wr_stat) begin
        if ((min_r == no_value_r) || ($signed(min_r) > in_cell_value)) begin
          min_r <= in_cell_value;
        end
        if ((max_r == no_value_r) || ($signed(max_r) < in_cell_value)) begin
          max_r <= in_cell_value;
        end
      end

      // window and clear walk: a single read only visits the centre
      if (accept) begin
        single_r <= (in_act == ACT_READ);
        kx_r     <= (in_act == ACT_READ) ? 2'd1 : 2'd0;
        ky_r     <= (in_act == ACT_READ) ? 2'd1 : 2'd0;
        cx_r     <= '0;
        cy_r     <= '0;
      end else if (state_r == ST_RD) begin
        if (kx_r == 2'd2) begin
          kx_r <= 2'd0;
          ky_r <= ky_r + 2'd1;
        end else begin
          kx_r <= kx_r + 2'd1;
        end
      end else if (state_r == ST_CLR) begin
        if (cx_last) begin
          cx_r <= '0;
          cy_r <= cy_r + ROW_W'(1);
        end else begin
          cx_r <= cx_r + COL_W'(1);
        end
      end

      pend_v_r <= (state_r == ST_RD);

      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      act_r <= in_act;
      col_r <= in_col;
      row_r <= in_row;
      ok_r  <= (in_act == ACT_CLEAR) ? 1'b1 : in_inside;
    end
    pend_kx_r <= kx_r;
    pend_ky_r <= ky_r;
    pend_in_r <= nb_inside;
    if (pend_v_r) begin
      win_r[pend_idx] <= pend_in_r ? rd_data_r : no_value_r;
    end
    if (load_out) begin
      for (int i = 0; i < 9; i++) begin
        if (act_r == ACT_WINDOW || (act_r == ACT_READ && i == 4)) begin
          out_win_r[i] <= win_r[i];
        end else begin
          out_win_r[i] <= '0;
        end
      end
      out_ok_r  <= ok_r;
      out_min_r <= min_r;
      out_max_r <= max_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_north_west = out_win_r[0];
  assign out_north      = out_win_r[1];
  assign out_north_east = out_win_r[2];
  assign out_west       = out_win_r[3];
  assign out_centre     = out_win_r[4];
  assign out_east       = out_win_r[5];
  assign out_south_west = out_win_r[6];
  assign out_south      = out_win_r[7];
  assign out_south_east = out_win_r[8];
  assign out_ok         = out_ok_r;
  assign out_min_seen   = out_min_r;
  assign out_max_seen   = out_max_r;

endmodule
`default_nettype wire
